@@ rtl/nsc_pkg.sv @@
// Package for the sentence checker: character codes, widths, FSM state type,
// controller/datapath command and status structs, hex digit decoder.
// No dependencies.
`default_nettype none

package nsc_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;
    localparam int SENT_CAP         = 64;
    localparam int CNT_W            = 7;
    localparam int IDX_W            = 6;
    localparam int CHAR_W           = 8;
    localparam int OUT_DATA_W       = 16;

    localparam logic [CNT_W-1:0]  LEN_RESET    = 7'd64;
    localparam logic [CHAR_W-1:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LC_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_F    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UC_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_F    = 8'h46;
    localparam logic [CHAR_W-1:0] HEX_ALPHA_OFS = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_DATA,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic store;
        logic clear;
        logic xor_en;
        logic digit;
        logic start_emit;
    } t_cmd;

    typedef struct packed {
        logic is_dollar;
        logic is_comma;
        logic is_star;
        logic over_limit;
        logic lim_zero;
        logic second_digit;
        logic sum_ok;
        logic emit_busy;
    } t_stat;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] hex_val(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] v;
        logic [4:0]        r;
        v = '0;
        r = 5'h10;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            v = ch - CHAR_ZERO;
            r = {1'b0, v[3:0]};
        end else if (ch >= CHAR_LC_A && ch <= CHAR_LC_F) begin
            v = ch - CHAR_LC_A + HEX_ALPHA_OFS;
            r = {1'b0, v[3:0]};
        end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_F) begin
            v = ch - CHAR_UC_A + HEX_ALPHA_OFS;
            r = {1'b0, v[3:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/nsc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
`default_nettype none

module nsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/nsc_datapath.sv @@
// Datapath: length limit register, checksum, store count, sentence buffer,
// read-out sequencing and output register. Depends on nsc_pkg, nsc_ram.
`default_nettype none

module nsc_datapath
    import nsc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CNT_W-1:0]        i_cfg_data,
    input  wire logic [CHAR_W-1:0]       i_char,
    input  wire t_cmd                    i_cmd,
    output t_stat                        o_stat,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic [CHAR_W-1:0]            o_out_char,
    output logic [IDX_W-1:0]             o_out_idx,
    output logic                         o_out_last
);

    localparam int AW      = $clog2(BUFFER_DEPTH);
    localparam int LIM_CAP = (BUFFER_DEPTH < SENT_CAP) ? BUFFER_DEPTH : SENT_CAP;

    logic [CNT_W-1:0]  r_max_len;
    logic [CHAR_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_dig_seen;
    logic [CHAR_W-1:0] r_prev_char;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_emit_len;
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_dat_idx;
    logic              r_out_vld;
    logic [CHAR_W-1:0] r_out_char;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_last;

    logic [CNT_W-1:0]  w_lim;
    logic [4:0]        w_hex_hi;
    logic [4:0]        w_hex_lo;
    logic              w_load;
    logic              w_rd_issue;
    logic [CHAR_W-1:0] w_rdata;

    assign w_lim = (r_max_len > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : r_max_len;

    assign w_hex_hi = hex_val(r_prev_char);
    assign w_hex_lo = hex_val(i_char);

    assign w_load     = r_rd_vld && (!r_out_vld || i_out_ready);
    assign w_rd_issue = (r_rd_idx != r_emit_len) && (!r_rd_vld || w_load);

    always_comb begin
        o_stat.is_dollar    = (i_char == CHAR_DOLLAR);
        o_stat.is_comma     = (i_char == CHAR_COMMA);
        o_stat.is_star      = (i_char == CHAR_STAR);
        o_stat.over_limit   = (r_count >= w_lim);
        o_stat.lim_zero     = (w_lim == '0);
        o_stat.second_digit = r_dig_seen;
        o_stat.sum_ok       = !w_hex_hi[4] && !w_hex_lo[4] &&
                              ({w_hex_hi[3:0], w_hex_lo[3:0]} == r_sum);
        o_stat.emit_busy    = (r_rd_idx != r_emit_len) || r_rd_vld;
    end

    always_comb begin
        n_sum = r_sum;
        if (i_cmd.clear) begin
            n_sum = '0;
        end else if (i_cmd.xor_en) begin
            n_sum = r_sum ^ i_char;
        end
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (i_cmd.store) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= LEN_RESET;
            r_sum      <= '0;
            r_count    <= '0;
            r_dig_seen <= 1'b0;
            r_rd_idx   <= '0;
            r_emit_len <= '0;
            r_rd_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_data;
            end
            r_sum   <= n_sum;
            r_count <= n_count;
            if (i_cmd.clear) begin
                r_dig_seen <= 1'b0;
            end else if (i_cmd.digit) begin
                r_dig_seen <= 1'b1;
            end
            if (i_cmd.start_emit) begin
                r_rd_idx   <= '0;
                r_emit_len <= r_count + 1'b1;
            end else if (w_rd_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
            if (w_rd_issue) begin
                r_rd_vld <= 1'b1;
            end else if (w_load) begin
                r_rd_vld <= 1'b0;
            end
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.digit) begin
            r_prev_char <= i_char;
        end
        if (w_rd_issue) begin
            r_dat_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (w_load) begin
            r_out_char <= w_rdata;
            r_out_idx  <= r_dat_idx;
            r_out_last <= (({1'b0, r_dat_idx} + 1'b1) == r_emit_len);
        end
    end

    nsc_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.store),
        .i_waddr (AW'(r_count)),
        .i_wdata (i_char),
        .i_re    (w_rd_issue),
        .i_raddr (AW'(r_rd_idx)),
        .o_rdata (w_rdata)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_char  = r_out_char;
    assign o_out_idx   = r_out_idx;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

@@ rtl/nsc_ctrl.sv @@
// Controller FSM: sentence framing phases and read-out phase; drives the
// datapath commands and the input ready. Depends on nsc_pkg.
`default_nettype none

module nsc_ctrl
    import nsc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   w_acc;

    assign o_in_ready = (r_state != ST_EMIT);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_stat.is_dollar && !i_stat.lim_zero) begin
                    n_state = ST_HEADER;
                end
            end
            ST_HEADER: begin
                if (w_acc) begin
                    if (i_stat.over_limit) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.is_comma) begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (w_acc) begin
                    if (i_stat.over_limit) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.is_star) begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (w_acc) begin
                    if (i_stat.over_limit) begin
                        n_state = ST_IDLE;
                    end else if (i_stat.second_digit) begin
                        n_state = i_stat.sum_ok ? ST_EMIT : ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (!i_stat.emit_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.store = w_acc && i_stat.is_dollar && !i_stat.lim_zero;
            end
            ST_HEADER: begin
                if (w_acc) begin
                    o_cmd.clear  = i_stat.over_limit;
                    o_cmd.store  = !i_stat.over_limit;
                    o_cmd.xor_en = !i_stat.over_limit;
                end
            end
            ST_DATA: begin
                if (w_acc) begin
                    o_cmd.clear  = i_stat.over_limit;
                    o_cmd.store  = !i_stat.over_limit;
                    o_cmd.xor_en = !i_stat.over_limit && !i_stat.is_star;
                end
            end
            ST_CHECK: begin
                if (w_acc) begin
                    o_cmd.clear      = i_stat.over_limit || i_stat.second_digit;
                    o_cmd.store      = !i_stat.over_limit;
                    o_cmd.digit      = !i_stat.over_limit && !i_stat.second_digit;
                    o_cmd.start_emit = !i_stat.over_limit && i_stat.second_digit &&
                                       i_stat.sum_ok;
                end
            end
            ST_EMIT: begin
                o_cmd = '0;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/nmea_sentence_checker_unit.sv @@
// Top level of the NMEA-0183 sentence checker: controller plus datapath.
// Depends on nsc_pkg, nsc_ctrl, nsc_datapath.
//
// Usage:
//   s_axis: one received character per request in tdata[7:0].
//   m_axis: one character of a checked sentence per request; tdata[7:0] is
//     the character, tdata[13:8] its position (0 is '$'), tlast marks the
//     second checksum digit.
//   cfg: write of the 7-bit sentence length limit, always ready.
// While a sentence is being framed, one character is taken per cycle.
// After the second checksum digit of a matching sentence, the characters
// are read from the sentence buffer's registered read port into the output
// register and appear on m_axis one per cycle. s_axis tready stays low
// while the stored characters are read out; a stalled receiver holds the
// read-out and thus the input. A failing sentence gives no output and does
// not hold the input.
// Reset (synchronous, active low) returns to idle, drops any partial
// sentence, empties the output register and sets the limit to 64. The
// sentence buffer needs no clearing pass.
`default_nettype none

module nmea_sentence_checker_unit
    import nsc_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [CHAR_W-1:0]     i_s_axis_tdata,  // [7:0] rx_char
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // [7:0] sentence_char,
                                                        // [13:8] char_index, pad
    output logic                       o_m_axis_tlast,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CNT_W-1:0]      i_cfg_data       // max_sentence_length
);

    t_cmd              w_cmd;
    t_stat             w_stat;
    logic [CHAR_W-1:0] w_out_char;
    logic [IDX_W-1:0]  w_out_idx;

    assign o_cfg_ready = 1'b1;

    nsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    nsc_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_char      (i_s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_char  (w_out_char),
        .o_out_idx   (w_out_idx),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W - CHAR_W - IDX_W){1'b0}}, w_out_idx, w_out_char};

endmodule

`default_nettype wire

@@ rtl/nsc_checker.sv @@
// Port-level checker for the sentence checker, bound to the top level.
// Depends on nsc_pkg.
`default_nettype none

module nsc_checker
    import nsc_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_s_axis_tready,
    input wire logic                  o_m_axis_tvalid,
    input wire logic                  i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input wire logic                  o_m_axis_tlast
);

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

    a_first_dollar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[13:8] == '0) |->
            (o_m_axis_tdata[7:0] == CHAR_DOLLAR) && !o_m_axis_tlast)
        else $error("sentence does not start with dollar");

    a_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> (o_m_axis_tdata[13:8] >= 6'd4))
        else $error("sentence too short");

    a_no_rx_mid_sentence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input taken during read-out");

endmodule

bind nmea_sentence_checker_unit nsc_checker u_nsc_checker (.*);

`default_nettype wire
